// ===== hdl/spc_pkg.sv =====
// Shared types and constants for the segment/plane clipper.
// No dependencies; imported by the datapath modules and the top level.
package spc_pkg;

    // Slice width used to split the wide interpolation multiply.
    localparam int CHUNK_W = 32;

    // Which endpoint distances came out negative.
    typedef struct packed {
        logic na;
        logic nb;
    } side_t;

endpackage

// ===== hdl/spc_dist.sv =====
// Distance front end: plane distances of both endpoints, their magnitudes and the divisor.
// Five register stages advancing on a shared enable. Depends on spc_pkg.
module spc_dist #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [12*COORD_WIDTH-1:0]    in_data,
    output logic                         out_valid,
    output logic [2*COORD_WIDTH+1:0]     den,
    output logic [2*COORD_WIDTH+1:0]     rem,
    output spc_pkg::side_t               side,
    output logic [9*COORD_WIDTH+2:0]     carry
);
    import spc_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;
    localparam int PW = 2 * W + 1;
    localparam int SW = 2 * W + 3;
    localparam int MW = 2 * W + 2;
    localparam int CW = 9 * W + 3;

    logic signed [W-1:0]  a_in [3];
    logic signed [W-1:0]  b_in [3];
    logic signed [W-1:0]  n_in [3];
    logic signed [W-1:0]  p_in [3];

    logic signed [DW-1:0] da1_reg [3];
    logic signed [DW-1:0] db1_reg [3];
    logic signed [DW-1:0] ln1_reg [3];
    logic signed [W-1:0]  n1_reg [3];
    logic [6*W-1:0]       ab1_reg;
    logic                 v1_reg;

    logic signed [PW-1:0] pa2_reg [3];
    logic signed [PW-1:0] pb2_reg [3];
    logic [3*W-1:0]       lmag2_reg;
    logic [2:0]           lneg2_reg;
    logic [6*W-1:0]       ab2_reg;
    logic                 v2_reg;
    logic [3*W-1:0]       lmag_next;
    logic [2:0]           lneg_next;

    logic signed [SW-1:0] sa3_reg;
    logic signed [SW-1:0] sb3_reg;
    logic [CW-1:0]        c3_reg;
    logic                 v3_reg;

    logic [MW-1:0]        ma4_reg;
    logic [MW-1:0]        mb4_reg;
    side_t                side4_reg;
    logic [CW-1:0]        c4_reg;
    logic                 v4_reg;
    logic [SW-1:0]        nega;
    logic [SW-1:0]        negb;

    logic [MW-1:0]        den5_reg;
    logic [MW-1:0]        rem5_reg;
    side_t                side5_reg;
    logic [CW-1:0]        c5_reg;
    logic                 v5_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            a_in[k] = in_data[k*W +: W];
            b_in[k] = in_data[(3+k)*W +: W];
            n_in[k] = in_data[(6+k)*W +: W];
            p_in[k] = in_data[(9+k)*W +: W];
        end
    end

    always_comb
    begin
        logic signed [DW-1:0] m;
        for (int k = 0; k < 3; k++)
        begin
            lneg_next[k]       = ln1_reg[k][DW-1];
            m                  = ln1_reg[k][DW-1] ? -ln1_reg[k] : ln1_reg[k];
            lmag_next[k*W +: W] = m[W-1:0];
        end
    end

    assign nega = -sa3_reg;
    assign negb = -sb3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                da1_reg[k] <= {a_in[k][W-1], a_in[k]} - {p_in[k][W-1], p_in[k]};
                db1_reg[k] <= {b_in[k][W-1], b_in[k]} - {p_in[k][W-1], p_in[k]};
                ln1_reg[k] <= {b_in[k][W-1], b_in[k]} - {a_in[k][W-1], a_in[k]};
                n1_reg[k]  <= n_in[k];
                pa2_reg[k] <= n1_reg[k] * da1_reg[k];
                pb2_reg[k] <= n1_reg[k] * db1_reg[k];
            end
            ab1_reg   <= in_data[6*W-1:0];
            lmag2_reg <= lmag_next;
            lneg2_reg <= lneg_next;
            ab2_reg   <= ab1_reg;

            sa3_reg <= {{2{pa2_reg[0][PW-1]}}, pa2_reg[0]}
                     + {{2{pa2_reg[1][PW-1]}}, pa2_reg[1]}
                     + {{2{pa2_reg[2][PW-1]}}, pa2_reg[2]};
            sb3_reg <= {{2{pb2_reg[0][PW-1]}}, pb2_reg[0]}
                     + {{2{pb2_reg[1][PW-1]}}, pb2_reg[1]}
                     + {{2{pb2_reg[2][PW-1]}}, pb2_reg[2]};
            c3_reg  <= {lneg2_reg, lmag2_reg, ab2_reg};

            side4_reg.na <= sa3_reg[SW-1];
            side4_reg.nb <= sb3_reg[SW-1];
            ma4_reg      <= sa3_reg[SW-1] ? nega[MW-1:0] : sa3_reg[MW-1:0];
            mb4_reg      <= sb3_reg[SW-1] ? negb[MW-1:0] : sb3_reg[MW-1:0];
            c4_reg       <= c3_reg;

            den5_reg  <= ma4_reg + mb4_reg;
            rem5_reg  <= ma4_reg;
            side5_reg <= side4_reg;
            c5_reg    <= c4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign den       = den5_reg;
    assign rem       = rem5_reg;
    assign side      = side5_reg;
    assign carry     = c5_reg;

endmodule

// ===== hdl/spc_div.sv =====
// Pipelined restoring divider: one quotient bit per stage for t = |dA| / (|dA| + |dB|).
// Produces 127 - 2*COORD_WIDTH quotient bits. Depends on spc_pkg.
module spc_div #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [2*COORD_WIDTH+1:0]      den,
    input  logic [2*COORD_WIDTH+1:0]      rem,
    input  spc_pkg::side_t                in_side,
    input  logic [9*COORD_WIDTH+2:0]      in_carry,
    output logic                          out_valid,
    output logic [126-2*COORD_WIDTH:0]    quot,
    output spc_pkg::side_t                out_side,
    output logic [9*COORD_WIDTH+2:0]      out_carry
);
    import spc_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int MW = 2 * W + 2;
    localparam int TF = 126 - 2 * W;
    localparam int QW = TF + 1;
    localparam int CW = 9 * W + 3;

    logic [MW-1:0] r_reg [TF];
    logic [MW-1:0] d_reg [TF];
    logic [QW-1:0] q_reg [QW];
    side_t         s_reg [QW];
    logic [CW-1:0] c_reg [QW];
    logic [QW-1:0] v_reg;

    for (genvar i = 0; i < QW; i++)
    begin : g_st
        logic [MW-1:0] r_src;
        logic [MW-1:0] d_src;
        logic [QW-1:0] q_src;
        side_t         s_src;
        logic [CW-1:0] c_src;
        logic          v_src;
        logic [MW:0]   t;
        logic [MW:0]   diff;
        logic          take;

        if (i == 0)
        begin : g_first
            assign r_src = rem;
            assign d_src = den;
            assign q_src = '0;
            assign s_src = in_side;
            assign c_src = in_carry;
            assign v_src = in_valid;
            // The integer bit of t is set only when the far distance is zero.
            assign t     = {1'b0, r_src};
        end
        else
        begin : g_next
            assign r_src = r_reg[i-1];
            assign d_src = d_reg[i-1];
            assign q_src = q_reg[i-1];
            assign s_src = s_reg[i-1];
            assign c_src = c_reg[i-1];
            assign v_src = v_reg[i-1];
            assign t     = {r_src, 1'b0};
        end

        assign diff = t - {1'b0, d_src};
        assign take = !diff[MW];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[i] <= {q_src[QW-2:0], take};
                s_reg[i] <= s_src;
                c_reg[i] <= c_src;
            end
        end

        if (i < TF)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[i] <= take ? diff[MW-1:0] : t[MW-1:0];
                    d_reg[i] <= d_src;
                end
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign quot      = q_reg[QW-1];
    assign out_side  = s_reg[QW-1];
    assign out_carry = c_reg[QW-1];

endmodule

// ===== hdl/spc_interp.sv =====
// Interpolation back end: t * |B - A| in 32-bit slices, rounding, offset from A,
// saturation and endpoint selection into the output register. Depends on spc_pkg.
module spc_interp #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [126-2*COORD_WIDTH:0]    quot,
    input  spc_pkg::side_t                in_side,
    input  logic [9*COORD_WIDTH+2:0]      in_carry,
    output logic                          out_valid,
    output logic                          keep,
    output logic [6*COORD_WIDTH-1:0]      out_data
);
    import spc_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int TF   = 126 - 2 * W;
    localparam int QW   = TF + 1;
    localparam int NCH  = (QW + CHUNK_W - 1) / CHUNK_W;
    localparam int PADW = NCH * CHUNK_W;
    localparam int PPW  = CHUNK_W + W;
    localparam int SUMW = PADW + W + 1;
    localparam int RW   = W + 2;

    logic [PADW-1:0]  tq_pad;
    logic [W-1:0]     lmag [3];

    logic [PPW-1:0]   pp1_reg [3][NCH];
    logic [6*W-1:0]   ab1_reg;
    logic [2:0]       ln1_reg;
    side_t            s1_reg;
    logic             v1_reg;

    logic [W:0]       dm_next [3];
    logic [W:0]       dm2_reg [3];
    logic [6*W-1:0]   ab2_reg;
    logic [2:0]       ln2_reg;
    side_t            s2_reg;
    logic             v2_reg;

    logic [W-1:0]     moved [3];
    logic [6*W-1:0]   data_next;

    logic [6*W-1:0]   data_reg;
    logic             keep_reg;
    logic             v3_reg;

    assign tq_pad = PADW'(quot);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            lmag[k] = in_carry[6*W + k*W +: W];
        end
    end

    // Sum the slice products and round half up at the binary point of t.
    always_comb
    begin
        logic [SUMW-1:0] acc;
        for (int k = 0; k < 3; k++)
        begin
            acc = SUMW'(1) << (TF - 1);
            for (int c = 0; c < NCH; c++)
            begin
                acc = acc + (SUMW'(pp1_reg[k][c]) << (c * CHUNK_W));
            end
            dm_next[k] = acc[TF +: W+1];
        end
    end

    always_comb
    begin
        logic signed [RW-1:0] ax;
        logic signed [RW-1:0] dx;
        logic signed [RW-1:0] r;
        for (int k = 0; k < 3; k++)
        begin
            ax = {{2{ab2_reg[k*W+W-1]}}, ab2_reg[k*W +: W]};
            dx = RW'(dm2_reg[k]);
            r  = ln2_reg[k] ? ax - dx : ax + dx;
            if (r[RW-1:W-1] != '0 && r[RW-1:W-1] != '1)
            begin
                moved[k] = r[RW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end
            else
            begin
                moved[k] = r[W-1:0];
            end
        end
        data_next = ab2_reg;
        if (s2_reg.na && !s2_reg.nb)
        begin
            data_next[3*W-1:0] = {moved[2], moved[1], moved[0]};
        end
        else if (!s2_reg.na && s2_reg.nb)
        begin
            data_next[6*W-1:3*W] = {moved[2], moved[1], moved[0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int c = 0; c < NCH; c++)
                begin
                    pp1_reg[k][c] <= tq_pad[c*CHUNK_W +: CHUNK_W] * lmag[k];
                end
                dm2_reg[k] <= dm_next[k];
            end
            ab1_reg  <= in_carry[6*W-1:0];
            ln1_reg  <= in_carry[9*W +: 3];
            s1_reg   <= in_side;
            ab2_reg  <= ab1_reg;
            ln2_reg  <= ln1_reg;
            s2_reg   <= s1_reg;
            data_reg <= data_next;
            keep_reg <= !(s2_reg.na && s2_reg.nb);
        end
    end

    assign out_valid = v3_reg;
    assign keep      = keep_reg;
    assign out_data  = data_reg;

endmodule

// ===== hdl/segment_plane_clip.sv =====
// Segment/plane clipper, fully pipelined: five distance stages, one divider stage per
// quotient bit, three back-end stages.
// Throughput is one word per cycle while the output does not stall; the divider depth sets most of the depth.
// An input skid register takes one more word while the output stalls.
// rst_n is asynchronous, active low, and clears all valid bits; data registers are not reset.
module segment_plane_clip #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, normal_x..z, anchor_x..z from bit 0 up
    input  logic [((12*COORD_WIDTH+7)/8)*8-1:0]       s_tdata,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z from bit 0 up
    output logic [((6*COORD_WIDTH+7)/8)*8-1:0]        m_tdata,
    // keep
    output logic                                      m_tuser
);
    import spc_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int OUT_W = ((6 * W + 7) / 8) * 8;
    localparam int MW    = 2 * W + 2;
    localparam int QW    = 127 - 2 * W;
    localparam int CW    = 9 * W + 3;

    logic              adv;
    logic              accept;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    logic [12*W-1:0]   skid_data_reg;
    logic              entry_valid;
    logic [12*W-1:0]   entry_data;

    logic              d_valid;
    logic [MW-1:0]     d_den;
    logic [MW-1:0]     d_rem;
    side_t             d_side;
    logic [CW-1:0]     d_carry;

    logic              q_valid;
    logic [QW-1:0]     q_quot;
    side_t             q_side;
    logic [CW-1:0]     q_carry;

    logic              o_valid;
    logic              o_keep;
    logic [6*W-1:0]    o_data;

    assign adv      = !o_valid || m_tready;
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    assign entry_valid = skid_valid_reg || accept;
    assign entry_data  = skid_valid_reg ? skid_data_reg : s_tdata[12*W-1:0];

    always_comb
    begin
        if (adv)
        begin
            skid_valid_next = 1'b0;
        end
        else
        begin
            skid_valid_next = skid_valid_reg || accept;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!adv && accept)
        begin
            skid_data_reg <= s_tdata[12*W-1:0];
        end
    end

    spc_dist #(.COORD_WIDTH(W)) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (entry_valid),
        .in_data   (entry_data),
        .out_valid (d_valid),
        .den       (d_den),
        .rem       (d_rem),
        .side      (d_side),
        .carry     (d_carry)
    );

    spc_div #(.COORD_WIDTH(W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (d_valid),
        .den       (d_den),
        .rem       (d_rem),
        .in_side   (d_side),
        .in_carry  (d_carry),
        .out_valid (q_valid),
        .quot      (q_quot),
        .out_side  (q_side),
        .out_carry (q_carry)
    );

    spc_interp #(.COORD_WIDTH(W)) u_interp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (q_valid),
        .quot      (q_quot),
        .in_side   (q_side),
        .in_carry  (q_carry),
        .out_valid (o_valid),
        .keep      (o_keep),
        .out_data  (o_data)
    );

    assign m_tvalid = o_valid;
    assign m_tuser  = o_keep;
    assign m_tdata  = OUT_W'(o_data);

endmodule

// ===== hdl/spc_check.sv =====
// Port-level checker for segment_plane_clip, attached by the bind below.
// Depends only on the top level's ports.
module spc_check #(
    parameter int COORD_WIDTH = 32
) (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  s_tvalid,
    input logic                                  s_tready,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [((6*COORD_WIDTH+7)/8)*8-1:0]    m_tdata,
    input logic                                  m_tuser
);

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // The skid register only fills when a word arrives during an output stall.
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid && m_tvalid && !m_tready))
        else $error("input ready dropped without an output stall");

    // Once the output moves, the skid word drains into the pipeline.
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready && !(m_tvalid && !m_tready) |=> s_tready)
        else $error("skid word did not drain");

endmodule

bind segment_plane_clip spc_check #(.COORD_WIDTH(COORD_WIDTH)) u_check (.*);

// ===== bench/testbench.sv =====
// Self-checking bench for segment_plane_clip: streams clip jobs in and checks each result word.
// Holds its own wide-integer clip predictor; depends only on the block.
`timescale 1ns / 1ps

module testbench;

    localparam int CW = 32;
    localparam int TSHIFT = 126 - 2 * CW;
    localparam logic signed [63:0] CMAX = 64'sd2147483647;
    localparam logic signed [63:0] CMIN = -64'sd2147483648;

    typedef logic [12*CW-1:0] seg_word_t;
    typedef struct packed {
        logic            keep;
        logic [6*CW-1:0] ends;
    } clip_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    seg_word_t s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [6*CW-1:0] m_tdata;
    logic m_tuser;

    seg_word_t segments_to_send[$];
    clip_t clips_due[$];
    int sent_count = 0;
    int clip_count = 0;
    int send_wait = 0;
    int recv_wait = 0;
    bit failed = 0;

    segment_plane_clip #(.COORD_WIDTH(CW)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Signed distances are exact in 128 bits; only the ratio and the signs matter.
    function automatic clip_t clip_segment(input seg_word_t w);
        logic signed [63:0] a[3], b[3], n[3], p[3], r[6];
        logic signed [127:0] da, db;
        logic [127:0] ma, mb, tq, pr;
        logic signed [63:0] line, dm, v;
        logic [63:0] mag;
        logic na, nb;
        int base;
        clip_t c;
        da = '0;
        db = '0;
        for (int k = 0; k < 3; k++)
        begin
            a[k] = $signed(w[CW*k +: CW]);
            b[k] = $signed(w[CW*(3+k) +: CW]);
            n[k] = $signed(w[CW*(6+k) +: CW]);
            p[k] = $signed(w[CW*(9+k) +: CW]);
            r[k] = a[k];
            r[3+k] = b[k];
        end
        for (int k = 0; k < 3; k++)
        begin
            da = da + 128'(n[k]) * 128'(a[k] - p[k]);
            db = db + 128'(n[k]) * 128'(b[k] - p[k]);
        end
        na = da[127];
        nb = db[127];
        c.keep = !(na && nb);
        if (na != nb)
        begin
            ma = na ? -da : da;
            mb = nb ? -db : db;
            tq = (ma << TSHIFT) / (ma + mb);
            base = na ? 0 : 3;
            for (int k = 0; k < 3; k++)
            begin
                line = b[k] - a[k];
                mag = line < 0 ? -line : line;
                pr = (tq * {64'd0, mag} + (128'd1 << (TSHIFT - 1))) >> TSHIFT;
                dm = pr[63:0];
                v = a[k] + (line < 0 ? -dm : dm);
                r[base+k] = v > CMAX ? CMAX : (v < CMIN ? CMIN : v);
            end
        end
        for (int k = 0; k < 6; k++)
            c.ends[CW*k +: CW] = r[k][CW-1:0];
        return c;
    endfunction

    function automatic logic [3*CW-1:0] vec(input logic [31:0] x, y, z);
        return {z, y, x};
    endfunction

    function automatic seg_word_t mk(input logic [3*CW-1:0] a, b, n, p);
        return {p, n, b, a};
    endfunction

    function automatic logic [31:0] rnd_coord();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            1, 2, 3: v = $urandom_range(0, 32'h80000) - 32'h40000;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic add_segment(input seg_word_t w);
        segments_to_send = {segments_to_send, w};
    endtask

    // Driver: one word at a time, random gap after each accepted word, none after words 300-399.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            send_wait = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                clips_due = {clips_due, clip_segment(s_tdata)};
                sent_count++;
                send_wait = (sent_count >= 300 && sent_count < 400) ? 0 : $urandom_range(0, 3);
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    s_tvalid <= 1'b0;
                end
                else if (segments_to_send.size() > 0)
                begin
                    s_tdata <= segments_to_send.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks results, stalls at random but not after results 300-449, once holds off long.
    always @(posedge clk or negedge rst_n)
    begin
        clip_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_wait = 3;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                clip_count++;
                if (clips_due.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, got keep=%0b ends=%h",
                             $time, m_tuser, m_tdata);
                    failed = 1;
                end
                else
                begin
                    want = clips_due.pop_front();
                    if (m_tuser !== want.keep)
                    begin
                        $display("%0t: keep mismatch, expected %0b, got %0b",
                                 $time, want.keep, m_tuser);
                        failed = 1;
                    end
                    for (int k = 0; k < 6; k++)
                        if (m_tdata[CW*k +: CW] !== want.ends[CW*k +: CW])
                        begin
                            $display("%0t: coordinate %0d mismatch, expected %h, got %h",
                                     $time, k, want.ends[CW*k +: CW], m_tdata[CW*k +: CW]);
                            failed = 1;
                        end
                end
                if (clip_count == 200)
                    recv_wait = 300;
                else if (clip_count >= 300 && clip_count < 450)
                    recv_wait = 0;
                else
                    recv_wait = $urandom_range(0, 3);
            end
            if (recv_wait > 0)
            begin
                recv_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        logic [31:0] one;
        one = 32'h10000;
        // The first two cases have a zero normal; the next seven use plane z = 0, normal pointing up.
        add_segment(mk('0, '0, '0, '0));
        add_segment(mk(vec(one, 2*one, -one), vec(-one, 5, -3*one), '0, vec(7, 8, 9)));
        add_segment(mk(vec(0, 0, one), vec(one, one, 2*one), vec(0, 0, one), '0));
        add_segment(mk(vec(0, 0, -one), vec(one, one, -2*one), vec(0, 0, one), '0));
        add_segment(mk(vec(0, 0, -one), vec(4*one, -one, 3*one), vec(0, 0, one), '0));
        add_segment(mk(vec(one, 3*one, 2*one), vec(-one, 0, -6*one), vec(0, 0, one), '0));
        add_segment(mk(vec(one, 0, 0), vec(0, one, -one), vec(0, 0, one), '0));
        add_segment(mk(vec(one, 0, -one), vec(0, one, 0), vec(0, 0, one), '0));
        add_segment(mk(vec(0, 0, 0), vec(0, 0, 0), vec(0, 0, one), '0));
        add_segment(mk({3{32'h7fffffff}}, '0, '0, '0));
        add_segment({12{32'h7fffffff}});
        add_segment({12{32'h80000000}});
        add_segment(mk(vec(32'h7fffffff, 32'h7fffffff, 32'h80000000),
                       vec(32'h80000000, 32'h80000000, 32'h7fffffff),
                       vec(0, 0, 32'h7fffffff), '0));
        add_segment(mk(vec(32'h80000000, 32'h7fffffff, 32'h80000000),
                       vec(32'h7fffffff, 32'h80000000, 32'h7fffffff),
                       vec(32'h80000000, 32'h7fffffff, 32'h80000000),
                       vec(32'h7fffffff, 32'h80000000, 32'h7fffffff)));
        add_segment(mk(vec(32'h7fffffff, 0, 32'h80000000),
                       vec(32'h80000000, 0, 32'h7fffffff),
                       vec(32'h80000000, 32'h80000000, 32'h80000000),
                       vec(32'h7fffffff, 32'h7fffffff, 32'h7fffffff)));
        add_segment(mk(vec(32'hffffffff, 1, 32'hffffffff), vec(1, 32'hffffffff, 1),
                       vec(1, 1, 1), '0));
        for (int i = 0; i < 600; i++)
        begin
            seg_word_t w;
            for (int k = 0; k < 12; k++)
                w[CW*k +: CW] = rnd_coord();
            add_segment(w);
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        while (segments_to_send.size() > 0 || s_tvalid || clips_due.size() > 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        if (!failed && clips_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #200000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
